// ----- design/assert_macros.svh -----
// Assertion macros used by the checker of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PQST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pqst_pkg.sv -----
// Package with the constants, codes and types of the priority queue.
package pqst_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int TYPE_COUNT  = 16;

   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int STOCK_IDX_W = $clog2(TYPE_COUNT);

   localparam int TAG_W  = 16;
   localparam int PRIO_W = 8;
   localparam int AMT_W  = 16;
   localparam int TYPE_W = 4;
   localparam int WAIT_W = 6;

   typedef enum logic [1:0] {
      CMD_PUSH        = 2'd0,
      CMD_POP         = 2'd1,
      CMD_POP_STOCK   = 2'd2,
      CMD_STOCK_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_PUSHED        = 3'd0,
      ST_DROPPED       = 3'd1,
      ST_POPPED        = 3'd2,
      ST_EMPTY         = 3'd3,
      ST_STOCK_WRITTEN = 3'd4
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [AMT_W-1:0]  amt;
      logic [TYPE_W-1:0] typ;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic empty;
      logic scan_last;
      logic rsp_free;
   } dp_sts_type;

endpackage

// ----- design/pqst_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface pqst_req_if;
   logic                              valid;
   logic                              ready;
   pqst_pkg::cmd_type                 cmd;
   logic [pqst_pkg::TAG_W-1:0]        item_tag;
   logic [pqst_pkg::PRIO_W-1:0]       priority_req;
   logic [pqst_pkg::AMT_W-1:0]        amount;
   logic [pqst_pkg::TYPE_W-1:0]       item_type;

   modport source (output valid, cmd, item_tag, priority_req, amount, item_type,
                   input ready);
   modport sink   (input valid, cmd, item_tag, priority_req, amount, item_type,
                   output ready);
endinterface

interface pqst_rsp_if;
   logic                              valid;
   logic                              ready;
   pqst_pkg::status_type              status;
   logic [pqst_pkg::TAG_W-1:0]        out_tag;
   logic [pqst_pkg::PRIO_W-1:0]       out_priority;
   logic [pqst_pkg::AMT_W-1:0]        out_amount;
   logic [pqst_pkg::TYPE_W-1:0]       out_type;
   logic [pqst_pkg::WAIT_W-1:0]       waiting_count;

   modport source (output valid, status, out_tag, out_priority, out_amount, out_type,
                   waiting_count, input ready);
   modport sink   (input valid, status, out_tag, out_priority, out_amount, out_type,
                   waiting_count, output ready);
endinterface

// ----- design/pqst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pqst_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pqst_dp.sv -----
// Datapath of the priority queue: entry RAM, stock table, scan compare and response register.
module pqst_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  pqst_pkg::dp_cmd_type          cmd,
   output pqst_pkg::dp_sts_type          sts,
   input  pqst_pkg::cmd_type             req_cmd,
   input  pqst_pkg::entry_type           req_entry,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pqst_pkg::status_type          rsp_status,
   output pqst_pkg::entry_type           rsp_entry,
   output logic [pqst_pkg::WAIT_W-1:0]   rsp_waiting_count
);

   typedef logic [pqst_pkg::IDX_W-1:0]       idx_type;
   typedef logic [pqst_pkg::COUNT_W-1:0]     count_type;
   typedef logic [pqst_pkg::STOCK_IDX_W-1:0] sidx_type;
   typedef logic [pqst_pkg::AMT_W-1:0]       amt_type;
   typedef logic [pqst_pkg::WAIT_W-1:0]      wait_type;

   pqst_pkg::cmd_type    req_cmd_ff;
   pqst_pkg::entry_type  req_entry_ff;
   count_type            count_ff;
   count_type            count_in;
   idx_type              scan_idx_ff;
   logic                 rd_vld_ff;
   idx_type              rd_idx_ff;
   pqst_pkg::entry_type  rd_entry;
   pqst_pkg::entry_type  best_ff;
   amt_type              best_gap_ff;
   idx_type              best_idx_ff;
   pqst_pkg::entry_type  last_ff;
   amt_type              stock_ff [pqst_pkg::TYPE_COUNT];
   amt_type              stock_val;
   amt_type              gap;
   logic                 take;
   logic                 stock_mode;
   logic                 is_pop;
   logic                 full;
   logic                 empty;
   logic                 ram_we;
   idx_type              ram_waddr;
   pqst_pkg::entry_type  ram_wdata;
   logic                 rsp_valid_ff;
   pqst_pkg::status_type rsp_status_ff;
   pqst_pkg::status_type rsp_status_in;
   pqst_pkg::entry_type  rsp_entry_ff;
   pqst_pkg::entry_type  rsp_entry_in;
   wait_type             rsp_wait_ff;
   wait_type             rsp_wait_in;

   assign is_pop     = req_cmd_ff inside {pqst_pkg::CMD_POP, pqst_pkg::CMD_POP_STOCK};
   assign stock_mode = (req_cmd_ff == pqst_pkg::CMD_POP_STOCK);
   assign full       = (count_ff == count_type'(pqst_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);

   assign sts.is_pop    = is_pop;
   assign sts.empty     = empty;
   assign sts.scan_last = (count_type'(scan_idx_ff) == count_ff - count_type'(1));
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Entry store: a push writes at the tail, a pop moves the last entry into the hole.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = best_idx_ff;
      ram_wdata = last_ff;
      if (cmd.commit) begin
         if (req_cmd_ff == pqst_pkg::CMD_PUSH) begin
            ram_we    = !full;
            ram_waddr = idx_type'(count_ff);
            ram_wdata = req_entry_ff;
         end else if (is_pop) begin
            ram_we = !empty;
         end
      end
   end

   pqst_ram #(
      .Width (pqst_pkg::ENTRY_W),
      .Depth (pqst_pkg::QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_entry)
   );

   // Stock level of the entry being compared; a type beyond the table reads as zero.
   always_comb begin
      stock_val = '0;
      if (int'(rd_entry.typ) < pqst_pkg::TYPE_COUNT) begin
         stock_val = stock_ff[sidx_type'(rd_entry.typ)];
      end
      gap  = (rd_entry.amt >= stock_val) ? (rd_entry.amt - stock_val)
                                         : (stock_val - rd_entry.amt);
      take = (rd_idx_ff == '0) || (rd_entry.prio > best_ff.prio) ||
             (stock_mode && (rd_entry.prio == best_ff.prio) && (gap < best_gap_ff));
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit) begin
         if ((req_cmd_ff == pqst_pkg::CMD_PUSH) && !full) begin
            count_in = count_ff + count_type'(1);
         end else if (is_pop && !empty) begin
            count_in = count_ff - count_type'(1);
         end
      end
   end

   always_comb begin
      rsp_entry_in  = '0;
      rsp_wait_in   = '0;
      case (req_cmd_ff)
         pqst_pkg::CMD_PUSH: begin
            rsp_status_in = full ? pqst_pkg::ST_DROPPED : pqst_pkg::ST_PUSHED;
         end
         pqst_pkg::CMD_STOCK_WRITE: begin
            rsp_status_in = pqst_pkg::ST_STOCK_WRITTEN;
         end
         default: begin
            if (empty) begin
               rsp_status_in = pqst_pkg::ST_EMPTY;
            end else begin
               rsp_status_in = pqst_pkg::ST_POPPED;
               rsp_entry_in  = best_ff;
               rsp_wait_in   = wait_type'(count_ff);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < pqst_pkg::TYPE_COUNT; i++) begin
            stock_ff[i] <= '0;
         end
      end else begin
         count_ff  <= count_in;
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit && (req_cmd_ff == pqst_pkg::CMD_STOCK_WRITE) &&
             (int'(req_entry_ff.typ) < pqst_pkg::TYPE_COUNT)) begin
            stock_ff[sidx_type'(req_entry_ff.typ)] <= req_entry_ff.amt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_cmd_ff   <= req_cmd;
         req_entry_ff <= req_entry;
         scan_idx_ff  <= '0;
      end else if (cmd.scan_rd) begin
         scan_idx_ff <= scan_idx_ff + idx_type'(1);
      end
      rd_idx_ff <= scan_idx_ff;
      if (rd_vld_ff) begin
         // Reads arrive in index order, so the final one is the last entry.
         last_ff <= rd_entry;
         if (take) begin
            best_ff     <= rd_entry;
            best_gap_ff <= gap;
            best_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_wait_ff   <= rsp_wait_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry         = rsp_entry_ff;
   assign rsp_waiting_count = rsp_wait_ff;

endmodule

// ----- design/pqst_ctrl.sv -----
// Controller state machine that sequences accept, scan, drain and commit.
module pqst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pqst_pkg::dp_sts_type sts,
   output pqst_pkg::dp_cmd_type cmd
);

   pqst_pkg::state_type state_ff;
   pqst_pkg::state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         pqst_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pqst_pkg::S_SCAN;
            end
         end
         pqst_pkg::S_SCAN: begin
            if (!sts.is_pop || sts.empty) begin
               state_in = pqst_pkg::S_FINISH;
            end else begin
               cmd.scan_rd = 1'b1;
               if (sts.scan_last) begin
                  state_in = pqst_pkg::S_DRAIN;
               end
            end
         end
         pqst_pkg::S_DRAIN: begin
            state_in = pqst_pkg::S_FINISH;
         end
         pqst_pkg::S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = pqst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pqst_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pqst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/priority_queue_stock_tiebreak.sv -----
// Top level of the linear-scan priority queue with stock tie-break.
//
//   Channel   Direction  Carries
//   req_ch    in         cmd, item_tag, priority_req, amount, item_type
//   rsp_ch    out        status, out_tag, out_priority, out_amount, out_type, waiting_count
//
// A push, a stock write or a pop on an empty queue goes from the scan state straight to the finish
// state, where it commits. A pop scans the entries through the entry RAM read port, one entry per
// cycle, then passes the drain state that covers the read latency; the commit writes the last
// entry back into the hole and returns to taking requests. A new request is taken while a
// response waits to be collected; its commit then waits for the response register to free up.
// Reset is synchronous and needs no clearing pass.
module priority_queue_stock_tiebreak (
   input  logic       clock,
   input  logic       reset,
   pqst_req_if.sink   req_ch,
   pqst_rsp_if.source rsp_ch
);

   pqst_pkg::dp_cmd_type dp_cmd;
   pqst_pkg::dp_sts_type dp_sts;
   pqst_pkg::entry_type  req_entry;
   pqst_pkg::entry_type  rsp_entry;

   assign req_entry.tag  = req_ch.item_tag;
   assign req_entry.prio = req_ch.priority_req;
   assign req_entry.amt  = req_ch.amount;
   assign req_entry.typ  = req_ch.item_type;

   pqst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   pqst_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .req_cmd           (req_ch.cmd),
      .req_entry         (req_entry),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_entry         (rsp_entry),
      .rsp_waiting_count (rsp_ch.waiting_count)
   );

   assign rsp_ch.out_tag      = rsp_entry.tag;
   assign rsp_ch.out_priority = rsp_entry.prio;
   assign rsp_ch.out_amount   = rsp_entry.amt;
   assign rsp_ch.out_type     = rsp_entry.typ;

endmodule

// ----- design/pqst_checker.sv -----
// Port-level checker for the priority queue and its bind to the top level.
`include "assert_macros.svh"

module pqst_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input pqst_pkg::status_type        rsp_status,
   input logic [pqst_pkg::TAG_W-1:0]  rsp_tag,
   input logic [pqst_pkg::PRIO_W-1:0] rsp_prio,
   input logic [pqst_pkg::AMT_W-1:0]  rsp_amount,
   input logic [pqst_pkg::TYPE_W-1:0] rsp_type,
   input logic [pqst_pkg::WAIT_W-1:0] rsp_wait
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pending_ff;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Requests taken whose response has not yet been transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         pending_ff <= pending_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_ff <= pending_ff - 2'd1;
      end
   end

   `PQST_ASSERT_NOW(a_no_invented_rsp, clock, reset, rsp_valid, pending_ff != 2'd0, "response without a request")
   `PQST_ASSERT_NOW(a_one_ahead, clock, reset, req_xfer, pending_ff <= 2'd1, "too many requests in flight")
   `PQST_ASSERT_NOW(a_zero_fields, clock, reset, rsp_valid && (rsp_status != pqst_pkg::ST_POPPED), (rsp_tag == '0) && (rsp_prio == '0) && (rsp_amount == '0) && (rsp_type == '0) && (rsp_wait == '0), "non-pop response carries data")
   `PQST_ASSERT_NOW(a_pop_count, clock, reset, rsp_valid && (rsp_status == pqst_pkg::ST_POPPED), rsp_wait != '0, "pop reports an empty queue")
   `PQST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response withdrawn before transfer")

endmodule

bind priority_queue_stock_tiebreak pqst_checker u_pqst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_tag    (rsp_ch.out_tag),
   .rsp_prio   (rsp_ch.out_priority),
   .rsp_amount (rsp_ch.out_amount),
   .rsp_type   (rsp_ch.out_type),
   .rsp_wait   (rsp_ch.waiting_count)
);
